>>> design/lsst_pkg.sv
package lsst_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] tan_t;

  localparam tan_t UNIT_Q14 = 16'sd16384;
  localparam logic [63:0] SHORT_SUMSQ_MIN = 64'd656;

  typedef enum logic [2:0] {
    REG_A_NORTH   = 3'd0,
    REG_A_EAST    = 3'd1,
    REG_A_DOWN    = 3'd2,
    REG_B_NORTH   = 3'd3,
    REG_B_EAST    = 3'd4,
    REG_B_DOWN    = 3'd5,
    REG_RADIUS    = 3'd6,
    REG_SPEED_MIN = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    tan_t tan_north;
    tan_t tan_east;
    tan_t tan_down;
  } tan_status_t;

endpackage

>>> design/lsst_tangent.sv
module lsst_tangent import lsst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  coord_t      wp_a [3],
  input  coord_t      wp_b [3],
  output tan_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SQ    = 6'b000100,
    S_ROOT  = 6'b001000,
    S_DIVLD = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t      state;
  logic [30:0] mag [3];
  logic [2:0]  neg;
  logic        big;
  logic [1:0]  idx;
  logic [63:0] sumsq;
  logic [63:0] root_x;
  logic [63:0] root_r;
  logic [63:0] bitm;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [15:0] numer_lo;
  logic [15:0] quo;
  tan_t        tan [3];

  logic signed [32:0] dsub [3];
  logic [32:0]        dmag [3];
  logic               big_next;
  logic [63:0]        sumsq_next;
  logic [63:0]        trial;
  logic [47:0]        numer;
  logic [33:0]        shifted;
  logic [33:0]        divisor;
  logic               qbit;
  logic [15:0]        q_full;
  logic [15:0]        q_clamp;

  always_comb begin
    big_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dsub[i] = {wp_b[i][31], wp_b[i]} - {wp_a[i][31], wp_a[i]};
      dmag[i] = dsub[i][32] ? 33'(-dsub[i]) : 33'(dsub[i]);
      if (dmag[i][32:31] != 2'b00) big_next = 1'b1;
    end
    sumsq_next = sumsq + 64'(mag[idx] * mag[idx]);
    trial      = root_r + bitm;
    numer      = {2'b00, mag[idx], 15'd0} + {16'd0, root_r[31:0]};
    shifted    = {rem, numer_lo[15]};
    divisor    = {1'b0, root_r[31:0], 1'b0};
    qbit       = shifted >= divisor;
    q_full     = {quo[14:0], qbit};
    q_clamp    = (q_full > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tan[0] <= UNIT_Q14;
      tan[1] <= '0;
      tan[2] <= '0;
    end else if (restart) begin
      state <= S_LOAD;
    end else begin
      case (state)
        S_LOAD: begin
          // halve all components when any one overflows 31 bits
          for (int i = 0; i < 3; i++) begin
            mag[i] <= big_next ? dmag[i][31:1] : dmag[i][30:0];
            neg[i] <= dsub[i][32];
          end
          big   <= big_next;
          sumsq <= '0;
          idx   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          sumsq <= sumsq_next;
          if (idx == 2'd2) begin
            if (!big && sumsq_next < SHORT_SUMSQ_MIN) begin
              tan[0] <= UNIT_Q14;
              tan[1] <= '0;
              tan[2] <= '0;
              state  <= S_IDLE;
            end else begin
              root_x <= sumsq_next;
              root_r <= '0;
              bitm   <= 64'd1 << 62;
              cnt    <= '0;
              state  <= S_ROOT;
            end
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_ROOT: begin
          if (root_x >= trial) begin
            root_x <= root_x - trial;
            root_r <= (root_r >> 1) + bitm;
          end else begin
            root_r <= root_r >> 1;
          end
          bitm <= bitm >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            idx   <= '0;
            state <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          // quotient fits in 16 bits, so the upper part starts below the divisor
          rem      <= {1'b0, numer[47:16]};
          numer_lo <= numer[15:0];
          quo      <= '0;
          cnt      <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          rem      <= qbit ? 33'(shifted - divisor) : shifted[32:0];
          quo      <= q_full;
          numer_lo <= {numer_lo[14:0], 1'b0};
          cnt      <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            tan[idx] <= neg[idx] ? -tan_t'(q_clamp) : tan_t'(q_clamp);
            if (idx == 2'd2) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_DIVLD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.busy      = (state != S_IDLE);
  assign status.tan_north = tan[0];
  assign status.tan_east  = tan[1];
  assign status.tan_down  = tan[2];

endmodule

>>> design/line_segment_switch_and_track_unit.sv
// channel  | dir | handshake                | payload
// s_axis   | in  | s_tvalid / s_tready      | s_tdata: pos n/e/d, vel n/e/d
// m_axis   | out | m_tvalid / m_tready      | m_tdata: closest n/e/d, tangent n/e/d;
//          |     |                          | m_tuser: switch_segment
// cfg      | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// six register stages, one word per cycle while s_tready is high.
// each config write recomputes the tangent with a bit-serial square root
// and divider, which a short segment skips by setting the tangent to north;
// s_tready is low meanwhile.
// reset clears the config registers to zero and the tangent to north.
// stages advance independently, so a stalled output fills the bubbles behind it.
module line_segment_switch_and_track_unit import lsst_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // pos_north, pos_east, pos_down, vel_north, vel_east, vel_down
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // closest_north, closest_east, closest_down,
                                  // tangent_north, tangent_east, tangent_down
  output logic [0:0]   m_tuser,   // switch_segment
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  coord_t      wp_a [3];
  coord_t      wp_b [3];
  logic [30:0] radius;
  coord_t      speed_min;
  logic [61:0] radius_sq;
  tan_status_t tstat;
  tan_t        tn [3];
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        wp_a[i] <= '0;
        wp_b[i] <= '0;
      end
      radius    <= '0;
      speed_min <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index))
        REG_A_NORTH:   wp_a[0]   <= cfg_data;
        REG_A_EAST:    wp_a[1]   <= cfg_data;
        REG_A_DOWN:    wp_a[2]   <= cfg_data;
        REG_B_NORTH:   wp_b[0]   <= cfg_data;
        REG_B_EAST:    wp_b[1]   <= cfg_data;
        REG_B_DOWN:    wp_b[2]   <= cfg_data;
        REG_RADIUS:    radius    <= cfg_data[30:0];
        REG_SPEED_MIN: speed_min <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radius_sq <= radius * radius;
  end

  lsst_tangent u_tangent (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .wp_a    (wp_a),
    .wp_b    (wp_b),
    .status  (tstat)
  );

  assign tn[0] = tstat.tan_north;
  assign tn[1] = tstat.tan_east;
  assign tn[2] = tstat.tan_down;

  // stage valids and advance chain
  logic v1, v2, v3, v4, v5, v6;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6 = !v6 || m_tready;
  assign adv5 = !v5 || adv6;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign s_tready = adv1 && !tstat.busy && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid && s_tready;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
    end
  end

  // stage 1: offsets from the waypoints
  logic signed [32:0] bp1 [3];
  logic signed [32:0] ap1 [3];
  coord_t             vel1 [3];

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        bp1[i]  <= {s_tdata[32*i+31], s_tdata[32*i +: 32]} - {wp_b[i][31], wp_b[i]};
        ap1[i]  <= {s_tdata[32*i+31], s_tdata[32*i +: 32]} - {wp_a[i][31], wp_a[i]};
        vel1[i] <= s_tdata[96+32*i +: 32];
      end
    end
  end

  // stage 2: products
  logic [32:0]        bmag [3];
  logic               far2_c;
  logic [61:0]        bsq2 [3];
  logic signed [47:0] pv2 [3];
  logic signed [48:0] pb2 [3];
  logic signed [48:0] pa2 [3];
  logic               far2;

  always_comb begin
    far2_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      bmag[i] = bp1[i][32] ? 33'(-bp1[i]) : 33'(bp1[i]);
      if (bmag[i][32:31] != 2'b00) far2_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      far2 <= far2_c;
      for (int i = 0; i < 3; i++) begin
        bsq2[i] <= bmag[i][30:0] * bmag[i][30:0];
        pv2[i]  <= vel1[i] * tn[i];
        pb2[i]  <= bp1[i] * tn[i];
        pa2[i]  <= ap1[i] * tn[i];
      end
    end
  end

  // stage 3: sums
  logic [63:0]        bsq3;
  logic signed [49:0] dv3;
  logic signed [50:0] dbp3;
  logic signed [50:0] dap3;
  logic               far3;

  always_ff @(posedge clk) begin
    if (adv3) begin
      far3 <= far2;
      bsq3 <= 64'(bsq2[0]) + 64'(bsq2[1]) + 64'(bsq2[2]);
      dv3  <= 50'(pv2[0]) + 50'(pv2[1]) + 50'(pv2[2]);
      dbp3 <= 51'(pb2[0]) + 51'(pb2[1]) + 51'(pb2[2]);
      dap3 <= 51'(pa2[0]) + 51'(pa2[1]) + 51'(pa2[2]);
    end
  end

  // stage 4: switch decision and projection products
  logic               prox4_c;
  logic               bear4_c;
  logic               sw4;
  logic signed [66:0] cp4 [3];

  always_comb begin
    prox4_c = !far3 && (bsq3 < {2'b00, radius_sq});
    bear4_c = 51'(dv3) > $signed({{5{speed_min[31]}}, speed_min, 14'd0});
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      sw4 <= (prox4_c && bear4_c) || (dbp3 > 51'sd0);
      for (int i = 0; i < 3; i++) begin
        cp4[i] <= dap3 * tn[i];
      end
    end
  end

  // stage 5: round by 2^28, ties away from zero
  logic [66:0]        cmag [3];
  logic [66:0]        crnd [3];
  logic signed [39:0] rs5 [3];
  logic               sw5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = cp4[i][66] ? 67'(-cp4[i]) : 67'(cp4[i]);
      crnd[i] = cmag[i] + (67'd1 << 28'd27);
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      sw5 <= sw4;
      for (int i = 0; i < 3; i++) begin
        rs5[i] <= cp4[i][66] ? -$signed({1'b0, crnd[i][66:28]})
                             :  $signed({1'b0, crnd[i][66:28]});
      end
    end
  end

  // stage 6: offset from A and saturate
  logic signed [40:0] csum [3];
  coord_t             csat [3];
  coord_t             out_c [3];
  logic               out_sw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = {{9{wp_a[i][31]}}, wp_a[i]} + {rs5[i][39], rs5[i]};
      if (csum[i][40:31] == 10'h000 || csum[i][40:31] == 10'h3ff) begin
        csat[i] = csum[i][31:0];
      end else if (csum[i][40]) begin
        csat[i] = 32'sh8000_0000;
      end else begin
        csat[i] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      out_sw <= sw5;
      for (int i = 0; i < 3; i++) out_c[i] <= csat[i];
    end
  end

  assign m_tvalid = v6;
  assign m_tuser  = out_sw;
  assign m_tdata  = {tn[2], tn[1], tn[0], out_c[2], out_c[1], out_c[0]};

endmodule
